// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types, constants and the lead byte decoder for the UTF-8 byte stream decoder.
// No dependencies.
package utf8d_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 31;
   localparam int unsigned LEN_W  = 3;
   localparam int unsigned LEAD_PAYLOAD_W = 7;
   localparam int unsigned CONT_BITS = 6;

   localparam logic [BYTE_W-1:0] LEAD1_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD1_PAT  = 8'h00;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD5_PAT  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFE;
   localparam logic [BYTE_W-1:0] LEAD6_PAT  = 8'hFC;

   localparam logic [LEN_W-1:0] LEN_INVALID = 3'd0;
   localparam logic [LEN_W-1:0] LEN_1       = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2       = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3       = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4       = 3'd4;
   localparam logic [LEN_W-1:0] LEN_5       = 3'd5;
   localparam logic [LEN_W-1:0] LEN_6       = 3'd6;

   typedef struct packed {
      logic [LEN_W-1:0]          len;
      logic [LEAD_PAYLOAD_W-1:0] payload;
   } lead_type;

   function automatic lead_type lead_decode(input logic [BYTE_W-1:0] b);
      lead_type r;
      r.len     = LEN_INVALID;
      r.payload = '0;
      if ((b & LEAD1_MASK) == LEAD1_PAT) begin
         r.len     = LEN_1;
         r.payload = b[6:0];
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
         r.len     = LEN_2;
         r.payload = {2'b00, b[4:0]};
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
         r.len     = LEN_3;
         r.payload = {3'b000, b[3:0]};
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
         r.len     = LEN_4;
         r.payload = {4'b0000, b[2:0]};
      end else if ((b & LEAD5_MASK) == LEAD5_PAT) begin
         r.len     = LEN_5;
         r.payload = {5'b00000, b[1:0]};
      end else if ((b & LEAD6_MASK) == LEAD6_PAT) begin
         r.len     = LEN_6;
         r.payload = {6'b000000, b[0]};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder: sequence state and result register.
// Depends on utf8d_pkg.
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   req     | req_valid, req_stall, req_in_byte                  | in
//   rsp     | rsp_valid, rsp_stall, rsp_code_point,              | out
//           | rsp_invalid_lead, rsp_bytes_used                   |
//
// One byte is taken per cycle while req_stall is low; the lead decode and the six-bit
// shift into the accumulator finish in the cycle the beat is accepted.
// A result appears in the cycle after the byte that completes it is accepted.
// Reset clears the sequence state and the result valid.
// req_stall is raised only while a result is held under rsp_stall.
module utf8_byte_stream_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [utf8d_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [utf8d_pkg::CP_W-1:0]     rsp_code_point,
   output logic                           rsp_invalid_lead,
   output logic [utf8d_pkg::LEN_W-1:0]    rsp_bytes_used
);
   import utf8d_pkg::*;

   logic [CP_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0] pending_ff, pending_in;
   logic [LEN_W-1:0] seq_len_ff, seq_len_in;
   logic             rsp_valid_ff;
   logic [CP_W-1:0]  rsp_cp_ff, rsp_cp_in;
   logic             rsp_inv_ff, rsp_inv_in;
   logic [LEN_W-1:0] rsp_used_ff, rsp_used_in;
   logic             emit;
   logic             accept;
   lead_type         lead;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign lead      = lead_decode(req_in_byte);

   always_comb begin
      acc_in      = acc_ff;
      pending_in  = pending_ff;
      seq_len_in  = seq_len_ff;
      emit        = 1'b0;
      rsp_cp_in   = '0;
      rsp_inv_in  = 1'b0;
      rsp_used_in = LEN_1;
      if (pending_ff == '0) begin
         if (lead.len == LEN_INVALID) begin
            emit       = 1'b1;
            rsp_inv_in = 1'b1;
         end else if (lead.len == LEN_1) begin
            emit      = 1'b1;
            rsp_cp_in = CP_W'(lead.payload);
         end else begin
            acc_in     = CP_W'(lead.payload);
            pending_in = lead.len - LEN_1;
            seq_len_in = lead.len;
         end
      end else begin
         acc_in     = {acc_ff[CP_W-CONT_BITS-1:0], req_in_byte[CONT_BITS-1:0]};
         pending_in = pending_ff - LEN_1;
         if (pending_ff == LEN_1) begin
            emit        = 1'b1;
            rsp_cp_in   = acc_in;
            rsp_used_in = seq_len_ff;
            acc_in      = '0;
            seq_len_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pending_ff   <= '0;
         seq_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            acc_ff     <= acc_in;
            pending_ff <= pending_in;
            seq_len_ff <= seq_len_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_cp_ff   <= rsp_cp_in;
         rsp_inv_ff  <= rsp_inv_in;
         rsp_used_ff <= rsp_used_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = rsp_cp_ff;
   assign rsp_invalid_lead = rsp_inv_ff;
   assign rsp_bytes_used   = rsp_used_ff;

   a_pending_below_len: assert property (@(posedge clock) disable iff (reset)
      pending_ff != '0 |-> seq_len_ff > pending_ff)
      else $error("pending count not below sequence length");

   a_invalid_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_inv_ff |-> rsp_cp_ff == '0 && rsp_used_ff == LEN_1)
      else $error("invalid lead result malformed");

   a_last_cont_emits: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff == LEN_1 |=>
         rsp_valid_ff && !rsp_inv_ff && rsp_used_ff == $past(seq_len_ff))
      else $error("completed sequence not delivered");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while result held");

endmodule
